// ----- hw/rtl/sequenced_crc_frame_builder_top_defines.svh -----
// Assertion macros for the frame builder.
// Used by scfb_back, the module that carries concurrent checks.
`ifndef SEQUENCED_CRC_FRAME_BUILDER_TOP_DEFINES_SVH
`define SEQUENCED_CRC_FRAME_BUILDER_TOP_DEFINES_SVH
// check that a condition implies another on the same edge
`define SCFB_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("check failed");
// check that a condition implies another on the following edge
`define SCFB_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("check failed");
`endif

// ----- hw/rtl/scfb_pkg.sv -----
// Types and constants of the frame builder.
// No dependencies.
`default_nettype none
package scfb_pkg;
	typedef struct packed {
		logic        kind;
		logic [7:0]  req_code;
		logic [15:0] request_length;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [1:0] {
		FK_IDLE = 2'd0,
		FK_DATA = 2'd1,
		FK_GET  = 2'd2,
		FK_SET  = 2'd3
	} fkind_t;

	// job codes: what the back part emits for one queued job
	typedef enum logic [2:0] {
		OP_HDR  = 3'd0,  // header, then body bytes, then optional tail
		OP_BYTE = 3'd1,  // zero to two bytes, then optional tail
		OP_ERR  = 3'd2,  // one error result
		OP_NONE = 3'd3
	} op_t;

	// job queued from front to back
	typedef struct packed {
		op_t        op;
		logic [15:0] seq;
		logic [7:0]  code;
		logic [7:0]  b0;      // first byte (payload or first body byte)
		logic [7:0]  b1;
		logic [2:0]  nbytes;  // body bytes after header / count for byte job
		logic [2:0]  nzero;   // zeros after them
		logic        crc;     // end with crc
		logic [1:0]  status;
	} job_t;

	localparam logic [7:0] FC_HB   = 8'd193;
	localparam logic [7:0] FC_DATA = 8'd194;
	localparam logic [7:0] FC_GET  = 8'd195;
	localparam logic [7:0] FC_SET  = 8'd196;
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CODE = 2'd1;
	localparam logic [1:0] ST_BIG  = 2'd2;
	localparam int HDR_LEN = 18;

	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [4:0] i, input logic [15:0] seq,
			input logic [7:0] code);
		logic [7:0] r;
		case (i)
			5'd0: r = 8'hA1;
			5'd1: r = 8'h1A;
			5'd2: r = seq[7:0];
			5'd3: r = seq[15:8];
			5'd6: r = 8'h01;
			5'd7: r = code;
			default: r = 8'h00;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/scfb_front.sv -----
// Front part: accepts items, tracks frame state, issues jobs.
// Depends on scfb_pkg.
`default_nettype none
module scfb_front import scfb_pkg::*; #(
	parameter int FRAME_LIMIT = 512
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t in_item,
	input  wire logic     take,
	output job_t          job,
	output logic          job_valid
);
	localparam logic [17:0] LIM = 18'(FRAME_LIMIT);

	logic [15:0] seq_q;
	fkind_t      kind_q;
	logic [15:0] rem_q;
	logic [15:0] idx_q;
	logic [7:0]  sbl_q;

	logic [17:0] total;
	logic [7:0]  sbl;
	logic        supp;
	logic [15:0] len;
	logic [7:0]  code;
	logic [15:0] seq_nx;
	logic [16:0] ptot;
	logic        last;

	assign len  = in_item.request_length;
	assign code = in_item.req_code;
	assign seq_nx = (seq_q == 16'hFFFF) ? 16'd1 : seq_q + 16'd1;
	assign ptot = {1'b0, idx_q} + {1'b0, rem_q};
	assign last = (rem_q == 16'd1);

	always_comb begin
		sbl = (len > 16'd2) ? 8'(len - 16'd2) : 8'd0;
		supp = 1'b1;
		case (code)
			FC_HB:   total = 18'd21;
			FC_DATA: total = 18'd22 + {2'b00, len};
			FC_GET:  total = 18'd24 + ((len > 16'd4) ? {2'b00, len - 16'd4} : 18'd0);
			FC_SET:  total = 18'd23 + {10'd0, sbl};
			default: begin
				total = 18'd0;
				supp = 1'b0;
			end
		endcase
	end

	always_comb begin
		job = '0;
		job.op = OP_NONE;
		job.seq = seq_q;
		job.code = code;
		job.b0 = in_item.data_byte;
		if (!in_item.kind) begin
			if (!supp) begin
				job.op = OP_ERR;
				job.status = ST_CODE;
			end else if (total > LIM) begin
				job.op = OP_ERR;
				job.status = ST_BIG;
			end else begin
				job.op = OP_HDR;
				case (code)
					FC_HB: begin
						job.b0 = 8'h06;
						job.nbytes = 3'd1;
						job.crc = 1'b1;
					end
					FC_DATA: begin
						job.b0 = len[7:0];
						job.b1 = len[15:8];
						job.nbytes = 3'd2;
						job.crc = (len == 16'd0);
					end
					FC_GET: begin
						job.nzero = (len == 16'd0) ? 3'd4 : 3'd0;
						job.crc = (len == 16'd0);
					end
					default: begin
						job.nzero = (len == 16'd0) ? 3'd3 : 3'd0;
						job.crc = (len == 16'd0);
					end
				endcase
			end
		end else if (kind_q != FK_IDLE && rem_q != 16'd0) begin
			job.op = OP_BYTE;
			job.crc = last;
			case (kind_q)
				FK_DATA: job.nbytes = 3'd1;
				FK_GET: begin
					job.nbytes = ((idx_q < 16'd2 && ptot < 17'd2) ||
						(idx_q >= 16'd2 && idx_q < 16'd4 && ptot < 17'd4)) ? 3'd0 : 3'd1;
					if (last && ptot < 17'd2) job.nzero = 3'd4;
					else if (last && ptot < 17'd4) job.nzero = 3'd2;
				end
				default: begin
					if (idx_q < 16'd2) begin
						if (ptot >= 17'd2) begin
							job.b1 = sbl_q;
							job.nbytes = (idx_q == 16'd1) ? 3'd2 : 3'd1;
						end
					end else if ((idx_q - 16'd2) < {8'd0, sbl_q}) begin
						job.nbytes = 3'd1;
					end
					if (last && ptot < 17'd2) job.nzero = 3'd3;
				end
			endcase
			if (job.nbytes == 3'd0 && job.nzero == 3'd0 && !job.crc) job.op = OP_NONE;
		end
	end

	assign job_valid = take && (job.op != OP_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
			kind_q <= FK_IDLE;
			rem_q <= '0;
			idx_q <= '0;
			sbl_q <= '0;
		end else if (take) begin
			if (!in_item.kind) begin
				kind_q <= FK_IDLE;
				rem_q <= '0;
				idx_q <= '0;
				sbl_q <= '0;
				if (supp && total <= LIM) begin
					seq_q <= seq_nx;
					if (code != FC_HB && len != 16'd0) begin
						rem_q <= len;
						sbl_q <= sbl;
						kind_q <= (code == FC_DATA) ? FK_DATA :
							(code == FC_GET) ? FK_GET : FK_SET;
					end
				end
			end else if (kind_q != FK_IDLE && rem_q != 16'd0) begin
				rem_q <= rem_q - 16'd1;
				idx_q <= idx_q + 16'd1;
				if (last) kind_q <= FK_IDLE;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/scfb_back.sv -----
// Back part: expands jobs into result bytes with running CRC.
// Depends on scfb_pkg and the defines header.
`default_nettype none
`include "sequenced_crc_frame_builder_top_defines.svh"
module scfb_back import scfb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t job,
	input  wire logic job_valid,
	output logic      job_take,
	output out_item_t out_item,
	output logic      out_valid,
	input  wire logic out_take
);
	// phase within a job: header count, body byte, zeros, crc lo, crc hi
	logic        busy_q;
	job_t        cur_q;
	logic [4:0]  hcnt_q;
	logic        in_hdr_q;
	logic [2:0]  bcnt_q;
	logic [2:0]  zcnt_q;
	logic [1:0]  ccnt_q;
	logic [15:0] crc_q;
	logic        ov_q;
	out_item_t   ob_q;

	logic        adv;
	out_item_t   nb;
	logic        crc_upd;
	logic        done;

	assign adv = !ov_q || out_take;

	always_comb begin
		nb = '0;
		crc_upd = 1'b0;
		done = 1'b0;
		if (cur_q.op == OP_ERR) begin
			nb.frame_end = 1'b1;
			nb.status = cur_q.status;
			done = 1'b1;
		end else if (in_hdr_q) begin
			nb.frame_byte = hdr_byte(hcnt_q, cur_q.seq, cur_q.code);
			crc_upd = 1'b1;
			done = (hcnt_q == 5'(HDR_LEN - 1)) && cur_q.nbytes == 3'd0 &&
				cur_q.nzero == 3'd0 && !cur_q.crc;
		end else if (bcnt_q != 3'd0) begin
			nb.frame_byte = (bcnt_q == cur_q.nbytes) ? cur_q.b0 : cur_q.b1;
			crc_upd = 1'b1;
			done = (bcnt_q == 3'd1) && cur_q.nzero == 3'd0 && !cur_q.crc;
		end else if (zcnt_q != 3'd0) begin
			crc_upd = 1'b1;
			done = (zcnt_q == 3'd1) && !cur_q.crc;
		end else if (ccnt_q == 2'd2) begin
			nb.frame_byte = crc_q[7:0];
		end else begin
			nb.frame_byte = crc_q[15:8];
			nb.frame_end = 1'b1;
			done = 1'b1;
		end
	end

	assign job_take = !busy_q || (adv && done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q <= 1'b0;
			crc_q <= 16'hFFFF;
			in_hdr_q <= 1'b0;
			hcnt_q <= '0;
			bcnt_q <= '0;
			zcnt_q <= '0;
			ccnt_q <= '0;
		end else begin
			if (out_take) ov_q <= 1'b0;
			if (busy_q && adv) begin
				ov_q <= 1'b1;
				if (crc_upd) crc_q <= crc_byte(crc_q, nb.frame_byte);
				if (in_hdr_q) begin
					hcnt_q <= hcnt_q + 5'd1;
					if (hcnt_q == 5'(HDR_LEN - 1)) in_hdr_q <= 1'b0;
				end else if (bcnt_q != 3'd0) bcnt_q <= bcnt_q - 3'd1;
				else if (zcnt_q != 3'd0) zcnt_q <= zcnt_q - 3'd1;
				else if (ccnt_q != 2'd0) ccnt_q <= ccnt_q - 2'd1;
				if (done) busy_q <= 1'b0;
			end
			if (job_take && job_valid) begin
				busy_q <= 1'b1;
				in_hdr_q <= (job.op == OP_HDR);
				hcnt_q <= '0;
				bcnt_q <= job.nbytes;
				zcnt_q <= job.nzero;
				ccnt_q <= job.crc ? 2'd2 : 2'd0;
				if (job.op == OP_HDR) crc_q <= 16'hFFFF;
			end
			if (busy_q && adv && done && cur_q.crc && cur_q.op != OP_ERR)
				if (!(job_take && job_valid && job.op == OP_HDR)) crc_q <= 16'hFFFF;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take && job_valid) cur_q <= job;
		if (busy_q && adv) ob_q <= nb;
	end

	assign out_item = ob_q;
	assign out_valid = ov_q;

	`SCFB_ASSERT_NXT(a_hold, clk, arst_n, ov_q && !out_take, ov_q && $stable(ob_q))
	`SCFB_ASSERT_IMP(a_take, clk, arst_n, job_valid && busy_q && !adv, !job_take)
	`SCFB_ASSERT_IMP(a_err, clk, arst_n, ov_q && ob_q.status != ST_OK, ob_q.frame_end)
endmodule
`default_nettype wire

// ----- hw/rtl/sequenced_crc_frame_builder_top.sv -----
// Sequenced CRC frame builder: one item per cycle in; the front decodes each
// start or payload item into a job, the back expands jobs into frame bytes
// with a byte-wise Modbus CRC-16. Payload bytes flow at one per cycle while the
// output is popped; a start item occupies the output for its 18-byte header plus
// body and CRC bytes, and the input stalls (full) while the back is busy with a longer job.
// Depends on scfb_pkg, scfb_front and scfb_back.
`default_nettype none
module sequenced_crc_frame_builder_top import scfb_pkg::*; #(
	parameter int FRAME_LIMIT = 512
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_item,
	input  wire logic      push,
	output logic           full,
	output out_item_t      out_item,
	output logic           empty,
	input  wire logic      pop
);
	job_t job;
	logic job_valid, job_take, out_valid, take;

	// one-entry job queue realized by the back accepting when done
	assign full = !job_take;
	assign take = push && job_take;
	assign empty = !out_valid;

	scfb_front #(.FRAME_LIMIT(FRAME_LIMIT)) u_front (
		.clk, .arst_n, .in_item, .take, .job, .job_valid
	);

	scfb_back u_back (
		.clk, .arst_n, .job, .job_valid, .job_take,
		.out_item, .out_valid, .out_take(pop)
	);
endmodule
`default_nettype wire

// ----- sim/sequenced_crc_frame_builder_checker.sv -----
// Frame checker: watches the request and result queues of the frame builder,
// predicts every frame byte and error result, and counts mismatches.
// Depends on scfb_pkg.
module sequenced_crc_frame_builder_checker import scfb_pkg::*; #(
	parameter int FRAME_LIMIT = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  logic      push,
	input  logic      full,
	input  out_item_t out_item,
	input  logic      empty,
	input  logic      pop,
	output int        fail_count,
	output int        pending_bytes
);
	out_item_t   frame_q[$];
	logic [15:0] seq_num;
	fkind_t      open_kind;
	logic [15:0] bytes_left;
	logic [15:0] byte_idx;
	logic [7:0]  set_len;
	logic [15:0] crc_acc;

	assign pending_bytes = frame_q.size();

	function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	task automatic push_result(input logic [7:0] b, input logic e, input logic [1:0] st);
		out_item_t r;
		r.frame_byte = b;
		r.frame_end = e;
		r.status = st;
		frame_q.push_back(r);
	endtask

	task automatic put_byte(input logic [7:0] b);
		crc_acc = crc_step(crc_acc, b);
		push_result(b, 1'b0, ST_OK);
	endtask

	task automatic put_zeros(input int n);
		for (int i = 0; i < n; i++)
			put_byte(8'h00);
	endtask

	task automatic close_frame();
		push_result(crc_acc[7:0], 1'b0, ST_OK);
		push_result(crc_acc[15:8], 1'b1, ST_OK);
		crc_acc = 16'hFFFF;
		open_kind = FK_IDLE;
	endtask

	task automatic predict_start(input logic [7:0] code, input logic [15:0] len);
		int total;
		logic [7:0] sbl;
		sbl = 8'h00;
		open_kind = FK_IDLE;
		byte_idx = 0;
		bytes_left = 0;
		set_len = 0;
		crc_acc = 16'hFFFF;
		if (code == FC_HB)
			total = 21;
		else if (code == FC_DATA)
			total = 22 + len;
		else if (code == FC_GET)
			total = 24 + (len > 4 ? len - 4 : 0);
		else if (code == FC_SET) begin
			sbl = (len > 2) ? 8'(len - 2) : 8'h00;
			total = 23 + sbl;
		end else begin
			push_result(8'h00, 1'b1, ST_CODE);
			return;
		end
		if (total > FRAME_LIMIT) begin
			push_result(8'h00, 1'b1, ST_BIG);
			return;
		end
		put_byte(8'hA1);
		put_byte(8'h1A);
		put_byte(seq_num[7:0]);
		put_byte(seq_num[15:8]);
		put_byte(8'h00);
		put_byte(8'h00);
		put_byte(8'h01);
		put_byte(code);
		put_zeros(10);
		seq_num = seq_num + 16'd1;
		if (seq_num == 0)
			seq_num = 16'd1;
		if (code == FC_HB) begin
			put_byte(8'h06);
			close_frame();
			return;
		end
		bytes_left = len;
		set_len = sbl;
		if (code == FC_DATA) begin
			put_byte(len[7:0]);
			put_byte(len[15:8]);
			open_kind = FK_DATA;
			if (len == 0)
				close_frame();
		end else if (code == FC_GET) begin
			open_kind = FK_GET;
			if (len == 0) begin
				put_zeros(4);
				close_frame();
			end
		end else begin
			open_kind = FK_SET;
			if (len == 0) begin
				put_zeros(3);
				close_frame();
			end
		end
	endtask

	task automatic predict_payload(input logic [7:0] b);
		int idx;
		int total;
		bit last;
		idx = byte_idx;
		total = byte_idx + bytes_left;
		if (open_kind == FK_IDLE || bytes_left == 0)
			return;
		bytes_left--;
		byte_idx++;
		last = (bytes_left == 0);
		if (open_kind == FK_DATA)
			put_byte(b);
		else if (open_kind == FK_GET) begin
			if (!((idx < 2 && total < 2) || (idx >= 2 && idx < 4 && total < 4)))
				put_byte(b);
			if (last && total < 2)
				put_zeros(4);
			else if (last && total < 4)
				put_zeros(2);
		end else begin
			if (idx < 2) begin
				if (total >= 2) begin
					put_byte(b);
					if (idx == 1)
						put_byte(set_len);
				end
			end else if (idx - 2 < set_len)
				put_byte(b);
			if (last && total < 2)
				put_zeros(3);
		end
		if (last)
			close_frame();
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			frame_q.delete();
			seq_num = 0;
			open_kind = FK_IDLE;
			bytes_left = 0;
			byte_idx = 0;
			set_len = 0;
			crc_acc = 16'hFFFF;
			fail_count = 0;
		end else begin
			if (pop && !empty) begin
				if (frame_q.size() == 0) begin
					fail_count++;
					$display("%0t: expected no result, got byte %h end %b status %0d",
						$time, out_item.frame_byte, out_item.frame_end, out_item.status);
				end else begin
					want = frame_q.pop_front();
					if (want !== out_item) begin
						fail_count++;
						$display("%0t: expected byte %h end %b status %0d,",
							$time, want.frame_byte, want.frame_end, want.status,
							" got byte %h end %b status %0d",
							out_item.frame_byte, out_item.frame_end, out_item.status);
					end
				end
			end
			if (push && !full) begin
				if (in_item.kind == 1'b0)
					predict_start(in_item.req_code, in_item.request_length);
				else
					predict_payload(in_item.data_byte);
			end
		end
	end
endmodule

// ----- sim/sequenced_crc_frame_builder_top_test.sv -----
// Testbench top: drives requests into the frame builder with random gaps and
// stalls; the checker beside the block predicts and compares.
// Depends on scfb_pkg, sequenced_crc_frame_builder_top and the checker.
module sequenced_crc_frame_builder_top_test;
	import scfb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic      clk;
	logic      arst_n;
	in_item_t  in_item;
	logic      push;
	logic      full;
	out_item_t out_item;
	logic      empty;
	logic      pop = 1'b0;
	int        fail_count;
	int        pending_bytes;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        cycle_count = 0;

	sequenced_crc_frame_builder_top DUT (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .push(push), .full(full),
		.out_item(out_item), .empty(empty), .pop(pop)
	);

	sequenced_crc_frame_builder_checker CHK (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .push(push), .full(full),
		.out_item(out_item), .empty(empty), .pop(pop), .fail_count(fail_count),
		.pending_bytes(pending_bytes)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// random receiver stalls
	always @(posedge clk)
		pop <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sequenced_crc_frame_builder_top_test NOT OK");
			$finish;
		end
	end

	// hold push until accepted; idle randomly between requests
	task automatic send_request(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		in_item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_start(input logic [7:0] code, input logic [15:0] len);
		in_item_t it;
		it.kind = 1'b0;
		it.req_code = code;
		it.request_length = len;
		it.data_byte = 8'($urandom);
		send_request(it);
	endtask

	task automatic send_payload(input logic [7:0] b);
		in_item_t it;
		it.kind = 1'b1;
		it.req_code = 8'($urandom);
		it.request_length = 16'($urandom);
		it.data_byte = b;
		send_request(it);
	endtask

	task automatic send_frame(input logic [7:0] code, input logic [15:0] len, input int sent);
		send_start(code, len);
		for (int i = 0; i < sent; i++)
			send_payload(8'($urandom));
	endtask

	task automatic random_phase(input int n);
		int left;
		int pick;
		int len;
		int sent;
		left = n;
		while (left > 0) begin
			pick = $urandom_range(99);
			len = ($urandom_range(9) == 0) ? $urandom_range(480) : $urandom_range(12);
			if (len > left)
				len = left;
			sent = 1;
			if (pick < 20) begin
				send_frame(FC_DATA, 16'(len), len);
				sent = len + 1;
			end else if (pick < 40) begin
				send_frame(FC_GET, 16'(len), len);
				sent = len + 1;
			end else if (pick < 60) begin
				send_frame(FC_SET, 16'(len), len);
				sent = len + 1;
			end else if (pick < 68)
				send_frame(FC_HB, 16'($urandom), 0);
			else if (pick < 76)
				send_start(8'($urandom), 16'($urandom));
			else if (pick < 84)
				send_start(8'($urandom_range(194, 196)), 16'($urandom_range(65535, 400)));
			else if (pick < 92) begin
				// abandon a partly sent frame
				sent = $urandom_range(2);
				send_frame(8'($urandom_range(194, 196)), 16'($urandom_range(3, 20)), sent);
				sent = sent + 1;
			end else
				send_payload(8'($urandom));
			left -= sent;
		end
		push <= 1'b0;
		@(posedge clk);
		while (pending_bytes != 0 && cycle_count < CYCLE_LIMIT)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed requests
		send_payload(8'hFF);
		send_frame(FC_HB, 16'hFFFF, 0);
		send_frame(FC_DATA, 16'd0, 0);
		send_frame(FC_DATA, 16'd2, 0);
		send_payload(8'hFF);
		send_payload(8'h00);
		send_frame(FC_GET, 16'd0, 0);
		send_frame(FC_GET, 16'd1, 1);
		send_frame(FC_GET, 16'd3, 3);
		send_frame(FC_SET, 16'd0, 0);
		send_frame(FC_SET, 16'd1, 1);
		send_frame(FC_SET, 16'd4, 4);
		send_start(8'h00, 16'd0);
		send_start(8'hFF, 16'hFFFF);
		send_start(FC_DATA, 16'd491);
		send_start(FC_SET, 16'd259);
		send_payload(8'hAA);
		send_start(FC_GET, 16'hFFFF);
		random_phase(80);
		send_idle_pct = 62;
		random_phase(90);
		send_idle_pct = 0;
		recv_stall_pct = 62;
		random_phase(90);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		random_phase(90);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending_bytes == 0)
			$display("sequenced_crc_frame_builder_top_test OK");
		else
			$display("sequenced_crc_frame_builder_top_test NOT OK");
		$finish;
	end
endmodule
